// ===== src/stpt_pkg.sv =====
// ----------------------------------------------------------------------------
// stpt_pkg
// Types and constants shared by the stepper tone generator modules.
// ----------------------------------------------------------------------------
package stpt_pkg;

    localparam logic [2:0] OP_TICK         = 3'd0;
    localparam logic [2:0] OP_NOTE_ON      = 3'd1;
    localparam logic [2:0] OP_NOTE_OFF     = 3'd2;
    localparam logic [2:0] OP_SET_MOVEMENT = 3'd3;
    localparam logic [2:0] OP_HALT_ALL     = 3'd4;
    localparam logic [2:0] OP_RESET_ALL    = 3'd5;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MAX   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NARROW_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NARROW_MAX = 2'd2;

    localparam logic [7:0] FULL_MAX_RST   = 8'd158;
    localparam logic [7:0] NARROW_MIN_RST = 8'd79;
    localparam logic [7:0] NARROW_MAX_RST = 8'd81;
    localparam logic [7:0] LED_ALL        = 8'hFF;

    typedef enum logic [2:0] {
        K_TICK,
        K_NOTE_ON,
        K_NOTE_OFF,
        K_SET_MOVE,
        K_HALT,
        K_RESET,
        K_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [2:0]  channel;
        logic        ch_ok;
        logic [15:0] period;
        logic        movement_enable;
    } cmd_t;

    typedef struct packed {
        logic [7:0] full_max;
        logic [7:0] narrow_min;
        logic [7:0] narrow_max;
    } travel_cfg_t;

endpackage

// ===== src/stpt_if.sv =====
// ----------------------------------------------------------------------------
// stpt request and result interfaces
// Valid/ready channels carrying command requests and output byte results.
// ----------------------------------------------------------------------------
interface stpt_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [2:0]  channel;
    logic [15:0] period_ticks;
    logic        movement_enable;

    modport source (output valid, operation, channel, period_ticks, movement_enable,
                    input ready);
    modport sink   (input valid, operation, channel, period_ticks, movement_enable,
                    output ready);
endinterface

interface stpt_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] direction_bits;
    logic [7:0] step_bits;
    logic [7:0] led_bits;
    logic       shift_out;

    modport source (output valid, direction_bits, step_bits, led_bits, shift_out,
                    input ready);
    modport sink   (input valid, direction_bits, step_bits, led_bits, shift_out,
                     output ready);
endinterface

// ===== src/multichannel_stepper_tone_generator.sv =====
// ----------------------------------------------------------------------------
// multichannel_stepper_tone_generator
// Drives up to CHANNELS stepper channels as square-wave tone generators.
//
// Requests arrive on the request channel (operation, channel, period_ticks,
// movement_enable) and each one produces exactly one result on the result
// channel: direction, step and LED bytes plus the shift_out flag.
// A decoder feeds a two-entry queue; the channel engine behind it runs the
// commands. A tick request walks the channels one per cycle through the
// shared counter and limit logic, and its result is emitted after the last
// channel; every other request returns a result the cycle after it leaves
// the queue. No new command starts until a tick's result has been emitted.
// The user must write the travel limits through cfg_we/cfg_index/cfg_data
// only while idle; the block itself does not enforce this. Reset clears all
// periods, counters, positions and modes, sets every LED bit and restores
// the default travel limits. A stalled result stays in the output register
// while the two-entry queue fills; a tick at its head is still swept.
module multichannel_stepper_tone_generator #(
    parameter int CHANNELS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    stpt_req_if.sink                       request,
    stpt_res_if.source                     result,
    input  logic                           cfg_we,
    input  logic [stpt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);
    import stpt_pkg::*;

    travel_cfg_t cfg_reg;
    logic        q_full;
    logic        push;
    cmd_t        push_data;
    logic        q_valid;
    cmd_t        q_data;
    logic        pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_max   <= FULL_MAX_RST;
            cfg_reg.narrow_min <= NARROW_MIN_RST;
            cfg_reg.narrow_max <= NARROW_MAX_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FULL_MAX:   cfg_reg.full_max   <= cfg_data;
                REG_NARROW_MIN: cfg_reg.narrow_min <= cfg_data;
                REG_NARROW_MAX: cfg_reg.narrow_max <= cfg_data;
                default:        cfg_reg            <= cfg_reg;
            endcase
        end
    end

    stpt_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .request   (request),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    stpt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop)
    );

    stpt_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_data  (q_data),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ===== src/stpt_front.sv =====
// ----------------------------------------------------------------------------
// stpt_front
// Accepts requests, decodes the operation and checks the channel number.
// ----------------------------------------------------------------------------
module stpt_front #(
    parameter int CHANNELS = 8
) (
    stpt_req_if.sink      request,
    input  logic          q_full,
    output logic          push,
    output stpt_pkg::cmd_t push_data
);
    import stpt_pkg::*;

    assign request.ready = !q_full;
    assign push          = request.valid && !q_full;

    always_comb
    begin
        push_data.channel         = request.channel;
        push_data.ch_ok           = ({1'b0, request.channel} < 4'(CHANNELS));
        push_data.period          = request.period_ticks;
        push_data.movement_enable = request.movement_enable;
        case (request.operation)
            OP_TICK:         push_data.kind = K_TICK;
            OP_NOTE_ON:      push_data.kind = K_NOTE_ON;
            OP_NOTE_OFF:     push_data.kind = K_NOTE_OFF;
            OP_SET_MOVEMENT: push_data.kind = K_SET_MOVE;
            OP_HALT_ALL:     push_data.kind = K_HALT;
            OP_RESET_ALL:    push_data.kind = K_RESET;
            default:         push_data.kind = K_NOP;
        endcase
    end

endmodule

// ===== src/stpt_queue.sv =====
// ----------------------------------------------------------------------------
// stpt_queue
// Two-entry command queue between the decoder and the channel engine.
// ----------------------------------------------------------------------------
module stpt_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  stpt_pkg::cmd_t push_data,
    output logic           full,
    output logic           q_valid,
    output stpt_pkg::cmd_t q_data,
    input  logic           pop
);
    import stpt_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== src/stpt_back.sv =====
// ----------------------------------------------------------------------------
// stpt_back
// Channel engine: executes commands, sweeps channels one per cycle on a
// tick, and holds the result in an output register.
// ----------------------------------------------------------------------------
module stpt_back #(
    parameter int CHANNELS = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  stpt_pkg::travel_cfg_t cfg,
    input  logic                  q_valid,
    input  stpt_pkg::cmd_t        q_data,
    output logic                  pop,
    stpt_res_if.source            result
);
    import stpt_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_EMIT
    } state_t;

    state_t          state_reg, state_next;
    logic [CH_W-1:0] idx_reg, idx_next;
    logic            shift_reg, shift_next;

    logic [15:0] period_reg [CHANNELS];
    logic [15:0] period_next [CHANNELS];
    logic [15:0] count_reg [CHANNELS];
    logic [15:0] count_next [CHANNELS];
    logic [7:0]  pos_reg [CHANNELS];
    logic [7:0]  pos_next [CHANNELS];
    logic        narrow_reg [CHANNELS];
    logic        narrow_next [CHANNELS];

    logic [7:0] dir_reg, dir_next;
    logic [7:0] step_reg, step_next;
    logic [7:0] led_reg, led_next;

    logic       res_valid_reg, res_valid_next;
    logic [7:0] res_dir_reg, res_dir_next;
    logic [7:0] res_step_reg, res_step_next;
    logic [7:0] res_led_reg, res_led_next;
    logic       res_shift_reg, res_shift_next;

    logic            out_free;
    logic            emit;
    logic [CH_W-1:0] sel;
    logic [2:0]      bit_sel;
    logic [15:0]     cnt_inc;
    logic [7:0]      lo;
    logic [7:0]      hi;
    logic            dir_bit;

    assign out_free              = !res_valid_reg || result.ready;
    assign result.valid          = res_valid_reg;
    assign result.direction_bits = res_dir_reg;
    assign result.step_bits      = res_step_reg;
    assign result.led_bits       = res_led_reg;
    assign result.shift_out      = res_shift_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        shift_next     = shift_reg;
        period_next    = period_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        narrow_next    = narrow_reg;
        dir_next       = dir_reg;
        step_next      = step_reg;
        led_next       = led_reg;
        res_valid_next = res_valid_reg && !result.ready;
        res_dir_next   = res_dir_reg;
        res_step_next  = res_step_reg;
        res_led_next   = res_led_reg;
        res_shift_next = res_shift_reg;
        pop            = 1'b0;
        emit           = 1'b0;

        sel     = (state_reg == S_SWEEP) ? idx_reg : q_data.channel[CH_W-1:0];
        bit_sel = (state_reg == S_SWEEP) ? 3'(idx_reg) : q_data.channel;
        cnt_inc = count_reg[sel] + 16'd1;
        lo      = narrow_reg[sel] ? cfg.narrow_min : 8'd0;
        hi      = narrow_reg[sel] ? cfg.narrow_max : cfg.full_max;
        dir_bit = dir_reg[bit_sel];
        if (pos_reg[sel] >= hi)
        begin
            dir_bit = 1'b1;
        end
        else if (pos_reg[sel] <= lo)
        begin
            dir_bit = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_data.kind == K_TICK)
                    begin
                        pop        = 1'b1;
                        idx_next   = '0;
                        shift_next = 1'b0;
                        state_next = S_SWEEP;
                    end
                    else if (out_free)
                    begin
                        pop        = 1'b1;
                        emit       = 1'b1;
                        shift_next = 1'b0;
                        case (q_data.kind)
                            K_NOTE_ON:
                            begin
                                if (q_data.ch_ok)
                                begin
                                    period_next[sel] = q_data.period;
                                    led_next[bit_sel] = 1'b0;
                                end
                                shift_next = 1'b1;
                            end
                            K_NOTE_OFF:
                            begin
                                if (q_data.ch_ok)
                                begin
                                    period_next[sel] = 16'd0;
                                    led_next[bit_sel] = 1'b1;
                                end
                                shift_next = 1'b1;
                            end
                            K_SET_MOVE:
                            begin
                                if (q_data.ch_ok)
                                begin
                                    narrow_next[sel] = !q_data.movement_enable;
                                end
                            end
                            K_HALT:
                            begin
                                for (int c = 0; c < CHANNELS; c++)
                                begin
                                    period_next[c] = 16'd0;
                                end
                                led_next   = LED_ALL;
                                shift_next = 1'b1;
                            end
                            K_RESET:
                            begin
                                for (int c = 0; c < CHANNELS; c++)
                                begin
                                    period_next[c] = 16'd0;
                                    pos_next[c]    = 8'd0;
                                    narrow_next[c] = 1'b0;
                                end
                                dir_next   = 8'd0;
                                step_next  = 8'd0;
                                led_next   = LED_ALL;
                                shift_next = 1'b1;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
            end
            S_SWEEP:
            begin
                if (period_reg[sel] != 16'd0)
                begin
                    if (cnt_inc >= period_reg[sel])
                    begin
                        count_next[sel]   = 16'd0;
                        dir_next[bit_sel] = dir_bit;
                        pos_next[sel]     = dir_bit ? pos_reg[sel] - 8'd1
                                                    : pos_reg[sel] + 8'd1;
                        step_next[bit_sel] = !step_reg[bit_sel];
                        shift_next        = 1'b1;
                    end
                    else
                    begin
                        count_next[sel] = cnt_inc;
                    end
                end
                if (idx_reg == CH_W'(CHANNELS - 1))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
        begin
            res_valid_next = 1'b1;
            res_dir_next   = dir_next;
            res_step_next  = step_next;
            res_led_next   = led_next;
            res_shift_next = shift_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            shift_reg     <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                period_reg[c] <= 16'd0;
                count_reg[c]  <= 16'd0;
                pos_reg[c]    <= 8'd0;
                narrow_reg[c] <= 1'b0;
            end
            dir_reg       <= 8'd0;
            step_reg      <= 8'd0;
            led_reg       <= LED_ALL;
            res_valid_reg <= 1'b0;
            res_dir_reg   <= 8'd0;
            res_step_reg  <= 8'd0;
            res_led_reg   <= LED_ALL;
            res_shift_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            shift_reg     <= shift_next;
            period_reg    <= period_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            narrow_reg    <= narrow_next;
            dir_reg       <= dir_next;
            step_reg      <= step_next;
            led_reg       <= led_next;
            res_valid_reg <= res_valid_next;
            res_dir_reg   <= res_dir_next;
            res_step_reg  <= res_step_next;
            res_led_reg   <= res_led_next;
            res_shift_reg <= res_shift_next;
        end
    end

endmodule
